[design/chfxy_pkg.sv]
package chfxy_pkg;

  // Table of atan(2^-i) in 2^-20 degree units
  localparam int ANG_TAB_LEN = 24;
  localparam int CORDIC_STEPS = 16;
  localparam int N_CELLS = (CORDIC_STEPS < ANG_TAB_LEN) ? CORDIC_STEPS : ANG_TAB_LEN;
  localparam int STEP_W = $clog2(ANG_TAB_LEN);

  // Datapath widths
  localparam int RD_W = 16;          // reading width
  localparam int MAG_W = RD_W + 1;   // magnitude of a reading
  localparam int FRAC_W = 16;        // fraction bits added before iterating
  localparam int XW = 35;            // iteration x/y width, covers CORDIC gain
  localparam int ZW = 28;            // angle accumulator width
  localparam int TW = 29;            // folded heading angle width
  localparam int HW = 15;            // heading width
  localparam int RND_SH = 14;        // 2^-20 degree to 2^-6 degree

  localparam logic [ZW-1:0] ANG_90 = ZW'(90 * 1048576);
  localparam logic [TW-1:0] ANG_180 = TW'(180 * 1048576);
  localparam logic [TW-1:0] ANG_360 = TW'(360 * 1048576);
  localparam logic [TW-1:0] RND_HALF = TW'(1 << (RND_SH - 1));

  localparam logic [HW-1:0] HEAD_0 = HW'(0);
  localparam logic [HW-1:0] HEAD_90 = HW'(5760);
  localparam logic [HW-1:0] HEAD_180 = HW'(11520);
  localparam logic [HW-1:0] HEAD_270 = HW'(17280);
  localparam logic [HW-1:0] HEAD_FULL = HW'(23040);

  // Sideband carried alongside the iterations
  typedef struct packed {
    logic            fixed;      // axis or zero case, heading known up front
    logic [HW-1:0]   fix_head;
    logic            valid_res;
    logic            x_neg;
    logic            y_neg;
  } side_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    side_t                side;
  } cordic_t;

  typedef struct packed {
    logic [TW-1:0] t;
    side_t         side;
  } fold_t;

  function automatic logic [ZW-1:0] atan_lookup(input logic [STEP_W-1:0] idx);
    logic [ZW-1:0] v;
    case (idx)
      5'd0:    v = ZW'(47185920);
      5'd1:    v = ZW'(27855475);
      5'd2:    v = ZW'(14718068);
      5'd3:    v = ZW'(7471121);
      5'd4:    v = ZW'(3750058);
      5'd5:    v = ZW'(1876857);
      5'd6:    v = ZW'(938658);
      5'd7:    v = ZW'(469357);
      5'd8:    v = ZW'(234682);
      5'd9:    v = ZW'(117342);
      5'd10:   v = ZW'(58671);
      5'd11:   v = ZW'(29335);
      5'd12:   v = ZW'(14668);
      5'd13:   v = ZW'(7334);
      5'd14:   v = ZW'(3667);
      5'd15:   v = ZW'(1833);
      5'd16:   v = ZW'(917);
      5'd17:   v = ZW'(458);
      5'd18:   v = ZW'(229);
      5'd19:   v = ZW'(115);
      5'd20:   v = ZW'(57);
      5'd21:   v = ZW'(29);
      5'd22:   v = ZW'(14);
      5'd23:   v = ZW'(7);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[design/chfxy_prep.sv]
module chfxy_prep (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       in_vld,
  input  logic [2*chfxy_pkg::RD_W-1:0] in_data,
  output logic                       out_vld,
  output chfxy_pkg::cordic_t         out_data
);
  import chfxy_pkg::*;

  logic signed [RD_W-1:0] x_rd, y_rd;
  logic [MAG_W-1:0] ax, ay;
  logic x_zero, y_zero;
  logic vld_r;
  cordic_t data_r, data_nxt;

  assign x_rd = in_data[RD_W-1:0];
  assign y_rd = in_data[2*RD_W-1:RD_W];
  assign x_zero = (x_rd == '0);
  assign y_zero = (y_rd == '0);

  // Take magnitudes and classify the axis cases
  always_comb begin
    ax = x_rd[RD_W-1] ? MAG_W'(-$signed({x_rd[RD_W-1], x_rd})) : MAG_W'(x_rd);
    ay = y_rd[RD_W-1] ? MAG_W'(-$signed({y_rd[RD_W-1], y_rd})) : MAG_W'(y_rd);
    data_nxt.x = $signed({{(XW-MAG_W-FRAC_W){1'b0}}, ax, {FRAC_W{1'b0}}});
    data_nxt.y = $signed({{(XW-MAG_W-FRAC_W){1'b0}}, ay, {FRAC_W{1'b0}}});
    data_nxt.z = '0;
    data_nxt.side.x_neg = x_rd[RD_W-1];
    data_nxt.side.y_neg = y_rd[RD_W-1];
    data_nxt.side.valid_res = !(x_zero && y_zero);
    data_nxt.side.fixed = x_zero || y_zero;
    if (x_zero && y_zero) begin
      data_nxt.side.fix_head = HEAD_0;
    end else if (y_zero) begin
      data_nxt.side.fix_head = x_rd[RD_W-1] ? HEAD_180 : HEAD_0;
    end else if (x_zero) begin
      data_nxt.side.fix_head = y_rd[RD_W-1] ? HEAD_270 : HEAD_90;
    end else begin
      data_nxt.side.fix_head = HEAD_0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_data = data_r;

endmodule

[design/chfxy_cell.sv]
module chfxy_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic [chfxy_pkg::STEP_W-1:0] step_idx,
  input  logic                        in_vld,
  input  chfxy_pkg::cordic_t          in_data,
  output logic                        out_vld,
  output chfxy_pkg::cordic_t          out_data
);
  import chfxy_pkg::*;

  logic signed [XW-1:0] x_in, y_in, xs, ys;
  logic signed [ZW-1:0] z_in, ang;
  logic vld_r;
  cordic_t data_r, data_nxt;

  assign x_in = in_data.x;
  assign y_in = in_data.y;
  assign z_in = in_data.z;
  assign xs = x_in >>> step_idx;
  assign ys = y_in >>> step_idx;
  assign ang = $signed(atan_lookup(step_idx));

  // Rotate toward the x axis by one micro-angle
  always_comb begin
    data_nxt = in_data;
    if (!y_in[XW-1]) begin
      data_nxt.x = x_in + ys;
      data_nxt.y = y_in - xs;
      data_nxt.z = z_in + ang;
    end else begin
      data_nxt.x = x_in - ys;
      data_nxt.y = y_in + xs;
      data_nxt.z = z_in - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_data = data_r;

endmodule

[design/chfxy_post.sv]
module chfxy_post (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     in_vld,
  input  chfxy_pkg::cordic_t       in_data,
  output logic                     out_vld,
  output logic [chfxy_pkg::HW-1:0] heading,
  output logic                     valid_res
);
  import chfxy_pkg::*;

  logic [ZW-1:0] a_clamp;
  logic [TW-1:0] a_ext, t_sum;
  logic [HW-1:0] head_rnd;
  logic vld_r;
  fold_t fold_r, fold_nxt;

  // Clamp the first-quadrant angle and fold it into its quadrant
  always_comb begin
    if (in_data.z[ZW-1]) begin
      a_clamp = '0;
    end else if (in_data.z > $signed(ANG_90)) begin
      a_clamp = ANG_90;
    end else begin
      a_clamp = in_data.z;
    end
    a_ext = TW'(a_clamp);
    fold_nxt.side = in_data.side;
    case ({in_data.side.x_neg, in_data.side.y_neg})
      2'b00:   fold_nxt.t = a_ext;
      2'b10:   fold_nxt.t = ANG_180 - a_ext;
      2'b11:   fold_nxt.t = ANG_180 + a_ext;
      2'b01:   fold_nxt.t = ANG_360 - a_ext;
      default: fold_nxt.t = a_ext;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fold_r <= fold_nxt;
    end
  end

  // Round to 1/64 degree, wrap 360 to 0, apply the axis cases
  assign t_sum = fold_r.t + RND_HALF;
  assign head_rnd = t_sum[TW-1:RND_SH];

  always_comb begin
    if (fold_r.side.fixed) begin
      heading = fold_r.side.fix_head;
    end else if (head_rnd >= HEAD_FULL) begin
      heading = HEAD_0;
    end else begin
      heading = head_rnd;
    end
  end

  assign valid_res = fold_r.side.valid_res;
  assign out_vld = vld_r;

endmodule

[design/compass_heading_from_xy.sv]
// Compass heading from a pair of magnetometer axis readings.
// Input channel: in_tdata carries X (bits 15:0) and Y (bits 31:16), both signed.
// Result channel: out_tdata carries the heading in 1/64 degree, 0..23039,
// counterclockwise from +X; out_tuser carries valid_res, low only when both
// readings are zero (heading then reads 0).
// Every input transaction gives exactly one result transaction, in order.
// The stages in order are: a register that takes the magnitudes, one cell
// per CORDIC iteration, a register that folds the angle into its quadrant
// and one output register.
// Throughput is one transaction per cycle while the receiver does not stall:
// each cell of the iteration chain holds one item and hands it on whenever the chain advances.
// When the receiver stalls with a result waiting, the whole chain holds and
// in_tready drops; it rises again the cycle out_tready is seen high.
// Reset (rst_n low at a clock edge) empties the chain; no result is pending
// after it and no state is kept between items.
module compass_heading_from_xy (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] x_reading, [31:16] y_reading
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [14:0] heading, [15] zero fill
  output logic        out_tuser   // [0] valid_res
);
  import chfxy_pkg::*;

  logic adv;
  logic cell_vld [0:N_CELLS];
  cordic_t cell_data [0:N_CELLS];
  logic post_vld;
  logic [HW-1:0] post_head;
  logic post_valid_res;
  logic out_vld_r;
  logic [HW-1:0] head_r;
  logic vres_r;

  // Advance the whole chain whenever the output slot can take a transaction
  assign adv = !out_vld_r || out_tready;
  assign in_tready = adv;

  chfxy_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (in_tvalid),
    .in_data  (in_tdata),
    .out_vld  (cell_vld[0]),
    .out_data (cell_data[0])
  );

  for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
    chfxy_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .step_idx (STEP_W'(g)),
      .in_vld   (cell_vld[g]),
      .in_data  (cell_data[g]),
      .out_vld  (cell_vld[g+1]),
      .out_data (cell_data[g+1])
    );
  end

  chfxy_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_vld    (cell_vld[N_CELLS]),
    .in_data   (cell_data[N_CELLS]),
    .out_vld   (post_vld),
    .heading   (post_head),
    .valid_res (post_valid_res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= post_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      head_r <= post_head;
      vres_r <= post_valid_res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata = {1'b0, head_r};
  assign out_tuser = vres_r;

  // Zero readings must come out with a zero heading
  a_zero_head: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == 16'd0))
    else $error("zero reading pair gave a nonzero heading");

  // Heading stays below a full turn
  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[HW-1:0] < HEAD_FULL))
    else $error("heading reached 360 degrees");

  // A stalled result freezes the fold stage behind it
  a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> ($stable(post_vld) && $stable(post_head)))
    else $error("fold stage moved during an output stall");

  // An empty output slot accepts the next input
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid && $past(rst_n)) |-> in_tready)
    else $error("input blocked with an empty output slot");

endmodule
